### hdl/bled_pkg.sv
package bled_pkg;

    localparam int PWM_STEPS_DEF = 100;
    localparam int LED_LINES_DEF = 8;

    localparam int DUTY_W  = 7;
    localparam int SPEED_W = 3;
    localparam int MS_W    = 6;
    localparam int SEG_W   = 7;

    localparam logic [DUTY_W-1:0]  DUTY_FULL   = 7'd100;
    localparam logic [DUTY_W-1:0]  DUTY_ZERO   = 7'd0;
    localparam logic [SPEED_W-1:0] SPEED_LOW   = 3'd1;
    localparam logic [SPEED_W-1:0] SPEED_HIGH  = 3'd5;
    localparam logic [SPEED_W-1:0] SPEED_RESET = 3'd3;

    localparam logic [1:0] CMD_PWM_TICK = 2'd0;
    localparam logic [1:0] CMD_MS_TICK  = 2'd1;
    localparam logic [1:0] CMD_KEY      = 2'd2;

    localparam logic [2:0] KEY_LIGHT   = 3'd1;
    localparam logic [2:0] KEY_BREATHE = 3'd2;
    localparam logic [2:0] KEY_SPEED   = 3'd3;
    localparam logic [2:0] KEY_COUNT   = 3'd4;

    typedef struct packed {
        logic [1:0] cmd;
        logic [2:0] key_code;
    } in_item_t;

    typedef struct packed {
        logic [7:0]         led_mask;
        logic [DUTY_W-1:0]  duty_level;
        logic [SPEED_W-1:0] speed_level;
        logic [3:0]         lit_count;
        logic               light_flag;
        logic               breathing_flag;
        logic [SEG_W-1:0]   segment_pattern;
    } out_item_t;

    // ramp step interval in ms for each speed
    function automatic logic [MS_W-1:0] delay_of(input logic [SPEED_W-1:0] speed);
        logic [MS_W-1:0] d;
        case (speed)
            3'd2:    d = 6'd25;
            3'd3:    d = 6'd18;
            3'd4:    d = 6'd12;
            3'd5:    d = 6'd7;
            default: d = 6'd35;
        endcase
        return d;
    endfunction

    // gfedcba pattern of the speed digit, blank outside 1..5
    function automatic logic [SEG_W-1:0] segment_of(input logic [SPEED_W-1:0] speed);
        logic [SEG_W-1:0] s;
        case (speed)
            3'd1:    s = 7'h06;
            3'd2:    s = 7'h5B;
            3'd3:    s = 7'h4F;
            3'd4:    s = 7'h66;
            3'd5:    s = 7'h6D;
            default: s = 7'h00;
        endcase
        return s;
    endfunction

endpackage

### hdl/bled_in_stage.sv
module bled_in_stage import bled_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_item,
    input  logic     take,
    output logic     in_valid,
    output in_item_t in_item
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    assign s_ready    = !valid_reg || take;
    assign valid_next = (s_valid && s_ready) ? 1'b1 : (take ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

    assign in_valid = valid_reg;
    assign in_item  = item_reg;

endmodule

### hdl/bled_core.sv
module bled_core import bled_pkg::*; #(
    parameter int PWM_STEPS = PWM_STEPS_DEF,
    parameter int LED_LINES = LED_LINES_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      take,
    input  in_item_t  in_item,
    output out_item_t result_next
);

    localparam int PW   = $clog2(PWM_STEPS);
    localparam int CW   = $clog2(LED_LINES + 1);
    localparam int CMPW = (PW > DUTY_W) ? PW : DUTY_W;
    localparam logic [PW:0]   PHASE_TOP   = (PW + 1)'(PWM_STEPS);
    localparam logic [CW-1:0] COUNT_TOP   = CW'(LED_LINES);
    localparam logic [CW-1:0] COUNT_ONE   = CW'(1);

    logic [PW-1:0]      phase_reg,   phase_next;
    logic [DUTY_W-1:0]  duty_reg,    duty_next;
    logic               falling_reg, falling_next;
    logic               light_reg,   light_next;
    logic               breathe_reg, breathe_next;
    logic [SPEED_W-1:0] speed_reg,   speed_next;
    logic [CW-1:0]      count_reg,   count_next;
    logic [MS_W-1:0]    ms_reg,      ms_next;

    logic [PW:0]        phase_inc;
    logic [MS_W-1:0]    ms_inc;
    logic               pwm_on;

    always_comb begin
        phase_next   = phase_reg;
        duty_next    = duty_reg;
        falling_next = falling_reg;
        light_next   = light_reg;
        breathe_next = breathe_reg;
        speed_next   = speed_reg;
        count_next   = count_reg;
        ms_next      = ms_reg;
        phase_inc    = {1'b0, phase_reg} + (PW + 1)'(1);
        ms_inc       = ms_reg + MS_W'(1);

        case (in_item.cmd)
            CMD_PWM_TICK: begin
                phase_next = (phase_inc >= PHASE_TOP) ? '0 : phase_inc[PW-1:0];
            end
            CMD_MS_TICK: begin
                if (ms_inc >= delay_of(speed_reg)) begin
                    ms_next = '0;
                    if (light_reg && breathe_reg) begin
                        if (!falling_reg) begin
                            if (duty_reg < DUTY_FULL) begin
                                duty_next = duty_reg + DUTY_W'(1);
                            end else begin
                                falling_next = 1'b1;
                            end
                        end else begin
                            if (duty_reg > DUTY_ZERO) begin
                                duty_next = duty_reg - DUTY_W'(1);
                            end else begin
                                falling_next = 1'b0;
                            end
                        end
                    end
                end else begin
                    ms_next = ms_inc;
                end
            end
            CMD_KEY: begin
                case (in_item.key_code)
                    KEY_LIGHT: begin
                        light_next   = !light_reg;
                        breathe_next = 1'b0;
                        if (!light_reg) begin
                            duty_next = DUTY_FULL;
                        end
                    end
                    KEY_BREATHE: begin
                        light_next   = 1'b1;
                        breathe_next = !breathe_reg;
                    end
                    KEY_SPEED: begin
                        speed_next = (speed_reg >= SPEED_HIGH) ? SPEED_LOW
                                                               : speed_reg + SPEED_W'(1);
                    end
                    KEY_COUNT: begin
                        count_next = (count_reg >= COUNT_TOP) ? COUNT_ONE
                                                              : count_reg + CW'(1);
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // result is built from the updated state
    always_comb begin
        pwm_on = light_next && ((duty_next >= DUTY_FULL) ||
                                (CMPW'(phase_next) < CMPW'(duty_next)));
        for (int j = 0; j < 8; j++) begin
            result_next.led_mask[j] = pwm_on && (j < LED_LINES) && (int'(count_next) > j);
        end
        result_next.duty_level      = duty_next;
        result_next.speed_level     = speed_next;
        result_next.lit_count       = 4'(count_next);
        result_next.light_flag      = light_next;
        result_next.breathing_flag  = breathe_next;
        result_next.segment_pattern = segment_of(speed_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= '0;
            duty_reg    <= DUTY_ZERO;
            falling_reg <= 1'b0;
            light_reg   <= 1'b1;
            breathe_reg <= 1'b1;
            speed_reg   <= SPEED_RESET;
            count_reg   <= COUNT_TOP;
            ms_reg      <= '0;
        end else if (take) begin
            phase_reg   <= phase_next;
            duty_reg    <= duty_next;
            falling_reg <= falling_next;
            light_reg   <= light_next;
            breathe_reg <= breathe_next;
            speed_reg   <= speed_next;
            count_reg   <= count_next;
            ms_reg      <= ms_next;
        end
    end

endmodule

### hdl/bled_out_stage.sv
module bled_out_stage import bled_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      in_valid,
    input  out_item_t result_next,
    output logic      take,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    logic      valid_reg;
    logic      valid_next;
    out_item_t item_reg;

    // the result register frees up in the same cycle its beat is taken
    assign take       = in_valid && (!valid_reg || m_ready);
    assign valid_next = take ? 1'b1 : (m_ready ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            item_reg <= result_next;
        end
    end

    assign m_valid = valid_reg;
    assign m_item  = item_reg;

endmodule

### hdl/breathing_led_pwm_controller_unit.sv
// Breathing LED PWM controller.
// Input channel s_valid/s_ready/s_item: one beat per event, cmd selects a
// PWM tick, a millisecond tick or a debounced key press (key_code 1..4).
// Result channel m_valid/m_ready/m_item: exactly one beat per input beat,
// in order, carrying LED mask, duty, speed, LED count, flags and the
// seven-segment pattern of the speed digit, all after the event is applied.
// Path: an accepted input beat passes the input register, then the result
// register, whose output drives m_valid and m_item. Throughput: one beat per
// cycle while the receiver does not stall; the state update and result build
// are combinational between the two registers.
// Reset (aresetn low, synchronous): both channels empty, light on,
// breathing on, duty 0 rising, speed 3, all LED lines, counters at zero.
// When the receiver stalls the result register holds its beat, one more
// beat waits in the input register, and s_ready then drops until m_ready.
module breathing_led_pwm_controller_unit import bled_pkg::*; #(
    parameter int PWM_STEPS = PWM_STEPS_DEF,
    parameter int LED_LINES = LED_LINES_DEF
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_item,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_item
);

    logic      take;
    logic      in_valid;
    in_item_t  in_item;
    out_item_t result_next;

    bled_in_stage u_in (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .take     (take),
        .in_valid (in_valid),
        .in_item  (in_item)
    );

    bled_core #(
        .PWM_STEPS (PWM_STEPS),
        .LED_LINES (LED_LINES)
    ) u_core (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .take        (take),
        .in_item     (in_item),
        .result_next (result_next)
    );

    bled_out_stage u_out (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (in_valid),
        .result_next (result_next),
        .take        (take),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item      (m_item)
    );

endmodule

### hdl/bled_checker.sv
module bled_checker import bled_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_item
);

    // stalled result beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("result beat changed while stalled");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("channels not empty after reset");

    a_duty_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_item.duty_level <= DUTY_FULL &&
                    m_item.speed_level >= SPEED_LOW && m_item.speed_level <= SPEED_HIGH)
        else $error("duty or speed out of range");

    a_dark_when_off: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_item.light_flag |-> m_item.led_mask == 8'd0 &&
                                          !m_item.breathing_flag)
        else $error("LEDs driven or breathing while light off");

    // two beats buffered at most: a stall with a full result register
    // must drop s_ready once the input register has filled
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready && s_valid && s_ready ##1 m_valid && !m_ready |-> !s_ready)
        else $error("input accepted beyond buffering");

endmodule

bind breathing_led_pwm_controller_unit bled_checker u_bled_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);
